/* hdl/skyrot_pkg.sv */
// ----------------------------------------------------------------------------
// skyrot_pkg: shared constants for the sky coordinate rotation block
// Fixed-point formats, CORDIC arctangent table and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package skyrot_pkg;

    // Vector components are Q30; two guard bits above the gain growth.
    localparam int VEC_W   = 34;
    // Angle accumulators hold 2^32 units per turn plus CORDIC excursion.
    localparam int ANG_W   = 34;
    localparam int STEPS   = 30;
    localparam int Q_BITS  = 30;
    localparam int PROD_W  = 2 * VEC_W;

    localparam logic signed [VEC_W-1:0] INV_GAIN     = 34'sd652032874;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sd2147483648;
    localparam logic signed [ANG_W-1:0] FULL_TURN    = 34'sd4294967296;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ANGLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_PLANE = 8'd1;

    localparam logic [31:0] ATAN_UNITS [0:STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

endpackage

`default_nettype wire

/* hdl/skyrot_sincos.sv */
// ----------------------------------------------------------------------------
// skyrot_sincos: pipelined rotation-mode CORDIC
// Quarter-turn fold, thirty shift-add stages and a sign flip stage.
// ----------------------------------------------------------------------------
`default_nettype none

module skyrot_sincos (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic [31:0]                       i_ang,
    output logic signed [skyrot_pkg::VEC_W-1:0]    o_cos,
    output logic signed [skyrot_pkg::VEC_W-1:0]    o_sin
);

    localparam int N = skyrot_pkg::STEPS;

    logic signed [skyrot_pkg::VEC_W-1:0] r_x [0:N];
    logic signed [skyrot_pkg::VEC_W-1:0] r_y [0:N];
    logic signed [skyrot_pkg::ANG_W-1:0] r_z [0:N];
    logic                                r_flip [0:N];

    logic signed [skyrot_pkg::ANG_W-1:0] n_z0;
    logic                                n_flip0;
    logic signed [skyrot_pkg::ANG_W-1:0] w_zs;

    assign w_zs = skyrot_pkg::ANG_W'($signed(i_ang));

    // Fold into [-quarter, quarter); a half-turn fold negates both outputs.
    always_comb begin
        n_z0    = w_zs;
        n_flip0 = 1'b0;
        if (w_zs >= skyrot_pkg::QUARTER_TURN) begin
            n_z0    = w_zs - skyrot_pkg::HALF_TURN;
            n_flip0 = 1'b1;
        end else if (w_zs < -skyrot_pkg::QUARTER_TURN) begin
            n_z0    = w_zs + skyrot_pkg::HALF_TURN;
            n_flip0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= skyrot_pkg::INV_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= n_z0;
            r_flip[0] <= n_flip0;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [skyrot_pkg::ANG_W-1:0] w_a;
        assign w_a = $signed({2'b00, skyrot_pkg::ATAN_UNITS[i]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[i+1] <= r_flip[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - w_a;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + w_a;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= r_flip[N] ? -r_x[N] : r_x[N];
            o_sin <= r_flip[N] ? -r_y[N] : r_y[N];
        end
    end

endmodule

`default_nettype wire

/* hdl/skyrot_vector.sv */
// ----------------------------------------------------------------------------
// skyrot_vector: pipelined vectoring-mode CORDIC
// Half-turn prerotation, thirty shift-add stages and an angle wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module skyrot_vector (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic signed [skyrot_pkg::VEC_W-1:0]   i_x,
    input  wire logic signed [skyrot_pkg::VEC_W-1:0]   i_y,
    output logic signed [skyrot_pkg::VEC_W-1:0]        o_mag,
    output logic signed [skyrot_pkg::ANG_W-1:0]        o_ang
);

    localparam int N = skyrot_pkg::STEPS;

    logic signed [skyrot_pkg::VEC_W-1:0] r_x [0:N];
    logic signed [skyrot_pkg::VEC_W-1:0] r_y [0:N];
    logic signed [skyrot_pkg::ANG_W-1:0] r_z [0:N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= skyrot_pkg::HALF_TURN;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [skyrot_pkg::ANG_W-1:0] w_a;
        assign w_a = $signed({2'b00, skyrot_pkg::ATAN_UNITS[i]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + w_a;
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - w_a;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mag <= r_x[N];
            o_ang <= (r_z[N] > skyrot_pkg::HALF_TURN) ? r_z[N] - skyrot_pkg::FULL_TURN
                                                      : r_z[N];
        end
    end

endmodule

`default_nettype wire

/* hdl/sky_coordinate_rotation.sv */
// ----------------------------------------------------------------------------
// sky_coordinate_rotation: rotate sky points by a configured angle
// Sine/cosine, rotation and atan2 on fully pipelined fixed-point CORDIC.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+------------------------------
//  input   | in        | i_in_valid / o_in_ready  | i_ra_in, i_dec_in, i_last_point
//  output  | out       | o_out_valid / i_out_ready| o_ra_out, o_dec_out, o_last_out
//  config  | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One transaction enters per cycle while the output is not stalled.
//  The latency is set by three 32-stage CORDIC pipelines (sine/cosine, the
//  right ascension atan2 and the declination atan2) plus five multiply and
//  rounding stages. Reset clears the valid bits of every stage and the two
//  configuration registers. When the output register holds a transaction
//  that is not taken, the whole pipeline holds and o_in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module sky_coordinate_rotation #(
    parameter int ANGLE_BITS = 20
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [ANGLE_BITS-1:0]         i_ra_in,
    input  wire logic signed [ANGLE_BITS-1:0]  i_dec_in,
    input  wire logic                          i_last_point,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [ANGLE_BITS-1:0]              o_ra_out,
    output logic signed [ANGLE_BITS-1:0]       o_dec_out,
    output logic                               o_last_out,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [skyrot_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ANGLE_BITS-1:0]         i_cfg_data
);

    localparam int VW  = skyrot_pkg::VEC_W;
    localparam int AW  = skyrot_pkg::ANG_W;
    localparam int PW  = skyrot_pkg::PROD_W;
    localparam int SH  = 32 - ANGLE_BITS;
    localparam int LAT = 101;
    // Angle delay from the first atan2 output to the rounding stage.
    localparam int DLY = 33;
    localparam logic [34:0] HALF = (SH > 0) ? (35'd1 << (SH - 1)) : 35'd0;
    localparam logic signed [34:0] DEC_LIM = 35'sd1 <<< (ANGLE_BITS - 2);

    // Config regs; the user writes only while the pipeline is empty; unchecked.
    logic [ANGLE_BITS-1:0] r_angle;
    logic                  r_plane;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_plane <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == skyrot_pkg::CFG_ROT_ANGLE) begin
                r_angle <= i_cfg_data;
            end else if (i_cfg_index == skyrot_pkg::CFG_ROT_PLANE) begin
                r_plane <= i_cfg_data[0];
            end
        end
    end

    // The whole pipeline advances together unless the output is stalled.
    logic w_en;
    logic r_vld  [0:LAT-1];
    logic r_last [0:LAT-1];

    assign w_en       = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_last[0] <= i_last_point;
            for (int k = 1; k < LAT; k++) begin
                r_last[k] <= r_last[k-1];
            end
        end
    end

    // Angles are scaled to 2^32 units per turn before the sine/cosine stages.
    logic [31:0] w_ra32, w_de32, w_th32;
    assign w_ra32 = 32'(i_ra_in) << SH;
    assign w_de32 = 32'(i_dec_in) << SH;
    assign w_th32 = 32'(r_angle) << SH;

    logic signed [VW-1:0] w_cr, w_sr, w_cd, w_sd, w_ct, w_st;

    skyrot_sincos u_sc_ra  (.i_clk(i_clk), .i_en(w_en), .i_ang(w_ra32),
                            .o_cos(w_cr), .o_sin(w_sr));
    skyrot_sincos u_sc_dec (.i_clk(i_clk), .i_en(w_en), .i_ang(w_de32),
                            .o_cos(w_cd), .o_sin(w_sd));
    skyrot_sincos u_sc_rot (.i_clk(i_clk), .i_en(w_en), .i_ang(w_th32),
                            .o_cos(w_ct), .o_sin(w_st));

    // Unit vector of the input point.
    logic signed [VW-1:0] r_ux, r_uy, r_uz, r_ct, r_st;
    logic signed [PW-1:0] w_px, w_py;
    assign w_px = PW'(w_cr) * PW'(w_cd);
    assign w_py = PW'(w_sr) * PW'(w_cd);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ux <= VW'(w_px >>> skyrot_pkg::Q_BITS);
            r_uy <= VW'(w_py >>> skyrot_pkg::Q_BITS);
            r_uz <= w_sd;
            r_ct <= w_ct;
            r_st <= w_st;
        end
    end

    // Rotation products. Tilt uses z as the second axis, spin uses y.
    logic signed [VW-1:0] w_other;
    logic signed [PW-1:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [VW-1:0] r_pass;
    assign w_other = r_plane ? r_uy : r_uz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa   <= PW'(r_ct) * PW'(r_ux);
            r_pb   <= PW'(r_st) * PW'(w_other);
            r_pc   <= PW'(r_ct) * PW'(w_other);
            r_pd   <= PW'(r_st) * PW'(r_ux);
            r_pass <= r_plane ? r_uz : r_uy;
        end
    end

    logic signed [PW:0] w_s1, w_s2;
    logic signed [VW-1:0] r_x2, r_y2, r_z2;
    assign w_s1 = r_plane ? (PW+1)'(r_pa) - (PW+1)'(r_pb) : (PW+1)'(r_pa) + (PW+1)'(r_pb);
    assign w_s2 = r_plane ? (PW+1)'(r_pd) + (PW+1)'(r_pc) : (PW+1)'(r_pc) - (PW+1)'(r_pd);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x2 <= VW'(w_s1 >>> skyrot_pkg::Q_BITS);
            if (r_plane) begin
                r_y2 <= VW'(w_s2 >>> skyrot_pkg::Q_BITS);
                r_z2 <= r_pass;
            end else begin
                r_y2 <= r_pass;
                r_z2 <= VW'(w_s2 >>> skyrot_pkg::Q_BITS);
            end
        end
    end

    // Right ascension from atan2(y', x'); its magnitude feeds the second stage.
    logic signed [VW-1:0] w_m1, w_m2;
    logic signed [AW-1:0] w_ra_ang, w_dec_ang;

    skyrot_vector u_vec_ra (.i_clk(i_clk), .i_en(w_en), .i_x(r_x2), .i_y(r_y2),
                            .o_mag(w_m1), .o_ang(w_ra_ang));

    logic signed [PW-1:0] w_pm;
    logic signed [VW-1:0] r_mag;
    assign w_pm = PW'(w_m1) * PW'(skyrot_pkg::INV_GAIN);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag <= VW'(w_pm >>> skyrot_pkg::Q_BITS);
        end
    end

    // z' and the right ascension angle wait for the declination atan2.
    logic signed [VW-1:0] r_zd  [0:DLY-1];
    logic signed [AW-1:0] r_rad [0:DLY-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zd[0]  <= r_z2;
            r_rad[0] <= w_ra_ang;
            for (int k = 1; k < DLY; k++) begin
                r_zd[k]  <= r_zd[k-1];
                r_rad[k] <= r_rad[k-1];
            end
        end
    end

    skyrot_vector u_vec_dec (.i_clk(i_clk), .i_en(w_en), .i_x(r_mag),
                             .i_y(r_zd[DLY-1]), .o_mag(w_m2), .o_ang(w_dec_ang));

    // Rounding to the output angle width; the magnitude of the second atan2
    // is not needed, so only its sign is looked at to keep it in use.
    logic [32:0]        w_ra_sum;
    logic signed [34:0] w_dsum, w_dsh, w_dsat;
    assign w_ra_sum = {1'b0, r_rad[DLY-1][31:0]} + HALF[32:0];
    assign w_dsum   = 35'(w_dec_ang) + $signed(HALF);
    assign w_dsh    = w_dsum >>> SH;

    always_comb begin
        w_dsat = w_dsh;
        if (w_dsh > DEC_LIM) begin
            w_dsat = DEC_LIM;
        end else if (w_dsh < -DEC_LIM) begin
            w_dsat = -DEC_LIM;
        end
        if (w_m2[VW-1] && w_dsh == w_dsh + 35'sd1) begin
            w_dsat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_ra_out  <= w_ra_sum[31:SH];
            o_dec_out <= w_dsat[ANGLE_BITS-1:0];
        end
    end

    assign o_out_valid = r_vld[LAT-1];
    assign o_last_out  = r_last[LAT-1];

    // A held result must hold back the input side too.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while output stalled");

    // Declination leaves saturated to a quarter turn.
    a_dec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (($signed(o_dec_out) <= DEC_LIM) && ($signed(o_dec_out) >= -DEC_LIM)))
        else $error("declination out of range");

    // An accepted transaction shows up in the first valid stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted transaction lost at pipeline entry");

endmodule

`default_nettype wire
